/* design/ifp_pkg.sv */
// Package for the IMU frame parser: phase and record codes, CRC step function.
// No dependencies.
package ifp_pkg;

   typedef enum logic [6:0] {
      PH_HUNT  = 7'b0000001,
      PH_SYNC2 = 7'b0000010,
      PH_LEN_L = 7'b0000100,
      PH_LEN_H = 7'b0001000,
      PH_CRC_L = 7'b0010000,
      PH_CRC_H = 7'b0100000,
      PH_BODY  = 7'b1000000
   } phase_type;

   typedef enum logic [2:0] {
      REC_TAG   = 3'd0,
      REC_ACC   = 3'd1,
      REC_GYRO  = 3'd2,
      REC_EULER = 3'd3,
      REC_FLOAT = 3'd4
   } rec_type;

   localparam logic [7:0] SYNC_A   = 8'h5A;
   localparam logic [7:0] SYNC_B   = 8'hA5;
   localparam logic [7:0] TAG_ACC  = 8'hA0;
   localparam logic [7:0] TAG_GYRO = 8'hB0;
   localparam logic [7:0] TAG_EUL  = 8'hD0;
   localparam logic [7:0] TAG_FLT  = 8'h91;
   localparam logic [15:0] LEN_SHORT = 16'd7;
   localparam logic [15:0] LEN_FLOAT = 16'd76;
   localparam logic [15:0] CRC_POLY  = 16'h1021;
   localparam int NUM_VALUES = 9;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_CRC_ERR   = 2'd1;
   localparam logic [1:0] ST_EMPTY_OK  = 2'd2;
   localparam logic [1:0] ST_EMPTY_ERR = 2'd3;

   typedef logic [31:0] value_array_type [NUM_VALUES];

   typedef struct packed {
      logic       wr_en;
      logic [3:0] idx;
      logic [1:0] lane;
      logic       half_hi;
      logic       is_float;
   } shadow_wr_type;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* design/ifp_record.sv */
// Record decoder of the IMU frame parser: turns payload bytes into shadow writes.
// Depends on ifp_pkg.
module ifp_record (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  clear,
   input  logic [7:0]            data,
   input  logic [15:0]           remaining,
   output ifp_pkg::shadow_wr_type wr,
   output logic                  fmt_set_all,
   output logic [2:0]            fmt_clear
);
   import ifp_pkg::*;

   rec_type    kind_ff, kind_in;
   logic [6:0] ofs_ff, ofs_in;
   logic [6:0] r;
   logic [2:0] pair;
   logic [1:0] slot;
   logic [6:0] fr;

   always_comb begin
      kind_in     = kind_ff;
      ofs_in      = ofs_ff;
      wr          = '0;
      fmt_set_all = 1'b0;
      fmt_clear   = 3'b000;
      r           = ofs_ff - 7'd1;
      pair        = r[3:1];
      slot        = (pair >= 3'd3) ? 2'(pair - 3'd3) : pair[1:0];
      fr          = 7'd0;
      case (kind_ff)
         REC_TAG: begin
            if (data == TAG_ACC && remaining >= LEN_SHORT) begin
               kind_in = REC_ACC; fmt_clear = 3'b001; ofs_in = 7'd1;
            end else if (data == TAG_GYRO && remaining >= LEN_SHORT) begin
               kind_in = REC_GYRO; fmt_clear = 3'b010; ofs_in = 7'd1;
            end else if (data == TAG_EUL && remaining >= LEN_SHORT) begin
               kind_in = REC_EULER; fmt_clear = 3'b100; ofs_in = 7'd1;
            end else if (data == TAG_FLT && remaining >= LEN_FLOAT) begin
               kind_in = REC_FLOAT; fmt_set_all = 1'b1; ofs_in = 7'd1;
            end
         end
         REC_ACC, REC_GYRO, REC_EULER: begin
            wr.wr_en   = 1'b1;
            wr.half_hi = r[0];
            case (kind_ff)
               REC_ACC:  wr.idx = {2'b00, slot};
               REC_GYRO: wr.idx = 4'd3 + {2'b00, slot};
               default:  wr.idx = (slot == 2'd0) ? 4'd7 : (slot == 2'd1) ? 4'd6 : 4'd8;
            endcase
            if (ofs_ff >= 7'd6) begin
               kind_in = REC_TAG; ofs_in = 7'd0;
            end else begin
               ofs_in = ofs_ff + 7'd1;
            end
         end
         REC_FLOAT: begin
            wr.is_float = 1'b1;
            if (ofs_ff >= 7'd12 && ofs_ff <= 7'd35) begin
               fr = ofs_ff - 7'd12;
               wr.wr_en = 1'b1;
               wr.idx = 4'(fr[6:2]);
            end else if (ofs_ff >= 7'd48 && ofs_ff <= 7'd59) begin
               fr = ofs_ff - 7'd48;
               wr.wr_en = 1'b1;
               wr.idx = 4'd6 + 4'(fr[6:2]);
            end
            wr.lane = fr[1:0];
            if (ofs_ff >= 7'd75) begin
               kind_in = REC_TAG; ofs_in = 7'd0;
            end else begin
               ofs_in = ofs_ff + 7'd1;
            end
         end
         default: begin
            kind_in = REC_TAG; ofs_in = 7'd0;
         end
      endcase
      if (!step) begin
         kind_in = kind_ff; ofs_in = ofs_ff; wr.wr_en = 1'b0;
         fmt_set_all = 1'b0; fmt_clear = 3'b000;
      end
      if (clear) begin
         kind_in = REC_TAG; ofs_in = 7'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff <= REC_TAG;
         ofs_ff  <= 7'd0;
      end else begin
         kind_ff <= kind_in;
         ofs_ff  <= ofs_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (kind_ff == REC_TAG) |-> (ofs_ff == 7'd0))
      else $error("record offset nonzero while waiting for a tag");
   assert property (@(posedge clock) disable iff (reset)
      (kind_ff == REC_ACC || kind_ff == REC_GYRO || kind_ff == REC_EULER)
      |-> (ofs_ff >= 7'd1 && ofs_ff <= 7'd6))
      else $error("short record offset out of range");
   assert property (@(posedge clock) disable iff (reset)
      wr.wr_en |-> (wr.idx < 4'd9))
      else $error("shadow write index out of range");
endmodule

/* design/imu_frame_parser_crc16.sv */
// Top level of the IMU frame parser with CRC-16/XMODEM check.
// Depends on ifp_pkg and ifp_record.
//
// The parser takes one byte of a serial stream per transfer on the req_ channel and
// hunts for frames that open with 5A A5, followed by a little-endian 16-bit payload
// length, a little-endian 16-bit CRC and the payload. The CRC-16/XMODEM covers the
// sync pair, the length and the payload. Records in the payload (A0, B0, D0 int16
// triples and the 76-byte 91 float record) are decoded into shadow registers as the
// bytes arrive; a matching CRC at the end of the frame makes them visible. One rsp_
// transfer is produced per complete frame with the status, the value format and all
// nine visible values. Each byte is handled by the logic between the input
// register and the result register, so one byte is accepted every cycle; the
// only stall comes from a result that has not been taken while the staged byte is the
// one that ends the next frame, which holds req_stall high until rsp_ is free.
module imu_frame_parser_crc16 (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_frame_status,
   output logic [2:0]  rsp_value_format,
   output logic [31:0] rsp_accel_x,
   output logic [31:0] rsp_accel_y,
   output logic [31:0] rsp_accel_z,
   output logic [31:0] rsp_gyro_x,
   output logic [31:0] rsp_gyro_y,
   output logic [31:0] rsp_gyro_z,
   output logic [31:0] rsp_pitch,
   output logic [31:0] rsp_roll,
   output logic [31:0] rsp_yaw
);
   import ifp_pkg::*;

   // Input register: holds the staged byte while the logic processes it; a stall keeps it in place.
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] rcrc_ff, rcrc_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] cnt_ff, cnt_in;
   value_array_type shadow_ff, shadow_in;
   value_array_type visible_ff, visible_in;
   logic [2:0]  sfmt_ff, sfmt_in;
   logic [2:0]  vfmt_ff, vfmt_in;

   logic        out_vld_ff;
   logic [1:0]  out_status_ff;
   logic [2:0]  out_fmt_ff;
   value_array_type out_val_ff;

   logic        emit;
   logic [1:0]  emit_status;
   logic        step;
   logic        rec_clear;
   logic [15:0] cnt_next;
   logic [15:0] crc_body;
   shadow_wr_type wr;
   logic        fmt_set_all;
   logic [2:0]  fmt_clear;
   logic [31:0] sv;
   logic        stage_stall;

   // The staged byte can move on unless it would produce a result while the
   // result register is still full and stalled.
   assign stage_stall = out_vld_ff && rsp_stall && in_vld_ff &&
                        ((phase_ff == PH_CRC_H && len_ff == 16'd0) ||
                         (phase_ff == PH_BODY && cnt_next >= len_ff));
   assign req_stall   = stage_stall;
   assign step        = in_vld_ff && !stage_stall;
   assign cnt_next    = cnt_ff + 16'd1;
   assign crc_body    = crc_step(crc_ff, in_byte_ff);
   assign rec_clear   = step && phase_ff == PH_CRC_H;

   ifp_record u_record (
      .clock       (clock),
      .reset       (reset),
      .step        (step && phase_ff == PH_BODY),
      .clear       (rec_clear || (step && phase_ff == PH_BODY && cnt_next >= len_ff)),
      .data        (in_byte_ff),
      .remaining   (len_ff - cnt_ff),
      .wr          (wr),
      .fmt_set_all (fmt_set_all),
      .fmt_clear   (fmt_clear)
   );

   always_comb begin
      phase_in    = phase_ff;
      len_in      = len_ff;
      rcrc_in     = rcrc_ff;
      crc_in      = crc_ff;
      cnt_in      = cnt_ff;
      shadow_in   = shadow_ff;
      visible_in  = visible_ff;
      sfmt_in     = sfmt_ff;
      vfmt_in     = vfmt_ff;
      emit        = 1'b0;
      emit_status = ST_OK;
      sv          = shadow_ff[wr.idx];
      if (step) begin
         case (phase_ff)
            PH_HUNT: begin
               if (in_byte_ff == SYNC_A) begin
                  crc_in = crc_step(16'h0000, in_byte_ff);
                  phase_in = PH_SYNC2;
               end
            end
            PH_SYNC2: begin
               if (in_byte_ff == SYNC_B) begin
                  crc_in = crc_body;
                  phase_in = PH_LEN_L;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LEN_L: begin
               len_in = {8'h00, in_byte_ff};
               crc_in = crc_body;
               phase_in = PH_LEN_H;
            end
            PH_LEN_H: begin
               len_in = {in_byte_ff, len_ff[7:0]};
               crc_in = crc_body;
               phase_in = PH_CRC_L;
            end
            PH_CRC_L: begin
               rcrc_in = {8'h00, in_byte_ff};
               phase_in = PH_CRC_H;
            end
            PH_CRC_H: begin
               rcrc_in = {in_byte_ff, rcrc_ff[7:0]};
               cnt_in  = 16'd0;
               if (len_ff != 16'd0) begin
                  shadow_in = visible_ff;
                  sfmt_in   = vfmt_ff;
                  phase_in  = PH_BODY;
               end else begin
                  phase_in    = PH_HUNT;
                  emit        = 1'b1;
                  emit_status = (crc_ff == {in_byte_ff, rcrc_ff[7:0]}) ?
                                ST_EMPTY_OK : ST_EMPTY_ERR;
               end
            end
            PH_BODY: begin
               if (wr.wr_en) begin
                  if (wr.is_float) begin
                     case (wr.lane)
                        2'd0:    sv[7:0]   = in_byte_ff;
                        2'd1:    sv[15:8]  = in_byte_ff;
                        2'd2:    sv[23:16] = in_byte_ff;
                        default: sv[31:24] = in_byte_ff;
                     endcase
                  end else if (!wr.half_hi) begin
                     sv = {24'h000000, in_byte_ff};
                  end else begin
                     sv = {{16{in_byte_ff[7]}}, in_byte_ff, sv[7:0]};
                  end
                  shadow_in[wr.idx] = sv;
               end
               if (fmt_set_all) begin
                  sfmt_in = 3'b111;
               end else begin
                  sfmt_in = sfmt_ff & ~fmt_clear;
               end
               crc_in = crc_body;
               cnt_in = cnt_next;
               if (cnt_next >= len_ff) begin
                  phase_in = PH_HUNT;
                  emit     = 1'b1;
                  if (crc_body == rcrc_ff) begin
                     visible_in  = shadow_in;
                     vfmt_in     = sfmt_in;
                     emit_status = ST_OK;
                  end else begin
                     emit_status = ST_CRC_ERR;
                  end
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         phase_ff   <= PH_HUNT;
         out_vld_ff <= 1'b0;
         len_ff     <= 16'd0;
         rcrc_ff    <= 16'd0;
         crc_ff     <= 16'd0;
         cnt_ff     <= 16'd0;
         sfmt_ff    <= 3'd0;
         vfmt_ff    <= 3'd0;
         for (int i = 0; i < NUM_VALUES; i++) begin
            shadow_ff[i]  <= 32'd0;
            visible_ff[i] <= 32'd0;
         end
      end else begin
         if (!stage_stall) begin
            in_vld_ff  <= req_valid;
            in_byte_ff <= req_data_byte;
         end
         phase_ff   <= phase_in;
         len_ff     <= len_in;
         rcrc_ff    <= rcrc_in;
         crc_ff     <= crc_in;
         cnt_ff     <= cnt_in;
         shadow_ff  <= shadow_in;
         visible_ff <= visible_in;
         sfmt_ff    <= sfmt_in;
         vfmt_ff    <= vfmt_in;
         if (emit) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_status_ff <= emit_status;
         out_fmt_ff    <= vfmt_in;
         out_val_ff    <= visible_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_frame_status = out_status_ff;
   assign rsp_value_format = out_fmt_ff;
   assign rsp_accel_x      = out_val_ff[0];
   assign rsp_accel_y      = out_val_ff[1];
   assign rsp_accel_z      = out_val_ff[2];
   assign rsp_gyro_x       = out_val_ff[3];
   assign rsp_gyro_y       = out_val_ff[4];
   assign rsp_gyro_z       = out_val_ff[5];
   assign rsp_pitch        = out_val_ff[6];
   assign rsp_roll         = out_val_ff[7];
   assign rsp_yaw          = out_val_ff[8];

   assert property (@(posedge clock) disable iff (reset)
      emit |-> !(out_vld_ff && rsp_stall))
      else $error("result overwritten while still pending");
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (cnt_ff < len_ff))
      else $error("payload count passed the frame length");
   assert property (@(posedge clock) disable iff (reset)
      (emit && emit_status == ST_CRC_ERR) |-> (vfmt_in == vfmt_ff))
      else $error("format changed on a CRC error");
endmodule
